// ----- design/rxp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rxp_pkg
// Shared types and constants of the replica exchange permuter.
// ----------------------------------------------------------------------------
package rxp_pkg;

  // default storage sizes
  localparam int DEF_MAX_REPLICAS = 16;
  localparam int DEF_MAX_PARAMS   = 4;

  // register and field widths
  localparam int NUM_REPLICAS_W = 5;
  localparam int NUM_PARAMS_W   = 3;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 5;

  // arithmetic widths
  localparam int MUL_W  = 32;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = 35;

  // divider: 4-bit divisor, 4 quotient bits per cycle
  localparam int DIVISOR_W        = 4;
  localparam int DIV_BITS_PER_CYC = 4;
  localparam int DIV_CNT_W        = 3;

  // exponential series and squaring
  localparam logic [DIVISOR_W-1:0] TAYLOR_FIRST = 4'd2;
  localparam logic [DIVISOR_W-1:0] TAYLOR_LAST  = 4'd13;
  localparam logic [1:0]           SQ_LAST      = 2'd3;

  localparam logic signed [31:0] W_MAX       = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] W_MIN       = 32'sh8000_0000;
  localparam logic signed [31:0] W_EXP_LIMIT = 32'sh0010_0000;

  typedef enum logic [1:0] {
    CMD_LOAD     = 2'd0,
    CMD_PERM_RST = 2'd1,
    CMD_SWAP     = 2'd2,
    CMD_READ     = 2'd3
  } rxp_cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_REPLICAS = 2'd0,
    REG_NUM_PARAMS   = 2'd1
  } rxp_reg_e;

endpackage

// ----- design/rxp_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rxp_ram
// Single port table memory with registered read data.
// ----------------------------------------------------------------------------
module rxp_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/rxp_perm.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rxp_perm
// Permutation slot memory. Per-slot valid bits give the identity mapping
// after reset or a clear; a slot not written since reads as its own index.
// ----------------------------------------------------------------------------
module rxp_perm #(
  parameter int MAX_REPLICAS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            clear_i,
  input  logic                            we_i,
  input  logic [$clog2(MAX_REPLICAS)-1:0] addr_i,
  input  logic [$clog2(MAX_REPLICAS)-1:0] wdata_i,
  output logic [$clog2(MAX_REPLICAS)-1:0] rdata_o
);

  localparam int RIW = $clog2(MAX_REPLICAS);

  logic [RIW-1:0]          mem [MAX_REPLICAS];
  logic [MAX_REPLICAS-1:0] valid_q;
  logic [RIW-1:0]          rdata_q;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (clear_i) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[addr_i] <= 1'b1;
    end
  end

  // storage and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= valid_q[addr_i] ? mem[addr_i] : addr_i;
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/rxp_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rxp_mul
// Shared 32x32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module rxp_mul (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [rxp_pkg::MUL_W-1:0]  a_i,
  input  logic [rxp_pkg::MUL_W-1:0]  b_i,
  output logic [rxp_pkg::PROD_W-1:0] prod_o
);

  import rxp_pkg::*;

  logic [PROD_W-1:0] prod_q;

  // product holds until the next enable
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= PROD_W'(a_i) * PROD_W'(b_i);
    end
  end

  assign prod_o = prod_q;

endmodule

// ----- design/rxp_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rxp_div
// Restoring divider of a 32-bit value by a 4-bit divisor, four quotient bits
// per cycle. done_o pulses with the quotient.
// ----------------------------------------------------------------------------
module rxp_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [rxp_pkg::MUL_W-1:0]     dividend_i,
  input  logic [rxp_pkg::DIVISOR_W-1:0] divisor_i,
  output logic                          done_o,
  output logic [rxp_pkg::MUL_W-1:0]     quotient_o
);

  import rxp_pkg::*;

  logic                 run_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [MUL_W-1:0]     quo_q, quo_d;
  logic [DIVISOR_W-1:0] rem_q, rem_d;

  // four restoring steps
  always_comb begin
    logic [DIVISOR_W:0] trial;
    rem_d = rem_q;
    quo_d = quo_q;
    for (int b = 0; b < DIV_BITS_PER_CYC; b++) begin
      trial = {rem_d, quo_d[MUL_W-1]};
      quo_d = {quo_d[MUL_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor_i}) begin
        trial    = trial - {1'b0, divisor_i};
        quo_d[0] = 1'b1;
      end
      rem_d = trial[DIVISOR_W-1:0];
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == '1) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // shift registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (run_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- design/replica_exchange_permuter_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// replica_exchange_permuter_core
// Replica exchange swap engine: parameter and derivative tables, a state
// permutation and a Metropolis test, driven by a small sequencer.
// ----------------------------------------------------------------------------
// Each command is taken when start is high and busy is low, and gives exactly
// one result, shown for one cycle with done_o high; the receiver cannot hold
// it off. Load, permutation reset and rejected requests give their result in
// the cycle after acceptance, a slot read after its S_RDSLOT state. A swap
// runs the permutation reads (S_PI, S_PJ), per parameter S_RD_A, S_RD_B,
// S_DIFF and S_ACC through the shared multiplier, and S_DECIDE for the
// decision; when 0 < weight < 16 the exponential follows: 12 series terms,
// each a multiply, a divider start and the wait for the divider's done, then
// the sum and four squarings, and S_CMP for the compare. An accepted swap adds
// the permutation writes S_SW1 and S_SW2. Configuration writes are always
// taken and must be made while idle.
module replica_exchange_permuter_core #(
  parameter int MAX_REPLICAS = rxp_pkg::DEF_MAX_REPLICAS,
  parameter int MAX_PARAMS   = rxp_pkg::DEF_MAX_PARAMS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rxp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rxp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     cmd_i,
  input  logic [3:0]                     replica_i,
  input  logic [1:0]                     param_index_i,
  input  logic signed [31:0]             derivative_value_i,
  input  logic signed [31:0]             state_value_i,
  input  logic [3:0]                     first_pick_i,
  input  logic [3:0]                     second_pick_i,
  input  logic [15:0]                    uniform_draw_i,
  output logic                           done_o,
  output logic                           accepted_o,
  output logic [3:0]                     first_replica_o,
  output logic [3:0]                     second_replica_o,
  output logic [3:0]                     slot_content_o,
  output logic [31:0]                    attempt_count_o,
  output logic [31:0]                    accept_count_o,
  output logic                           bad_request_o
);

  import rxp_pkg::*;

  localparam int RIW   = $clog2(MAX_REPLICAS);
  localparam int CIW   = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
  localparam int DEPTH = MAX_REPLICAS * MAX_PARAMS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RCW   = $clog2(MAX_REPLICAS + 1);
  localparam int PCW   = $clog2(MAX_PARAMS + 1);
  localparam int NRW   = (RCW > NUM_REPLICAS_W) ? RCW : NUM_REPLICAS_W;
  localparam int NPW   = (PCW > NUM_PARAMS_W) ? PCW : NUM_PARAMS_W;

  // sequencer states
  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_PI     = 5'd1;
  localparam logic [4:0] S_PJ     = 5'd2;
  localparam logic [4:0] S_RD_A   = 5'd3;
  localparam logic [4:0] S_RD_B   = 5'd4;
  localparam logic [4:0] S_DIFF   = 5'd5;
  localparam logic [4:0] S_ACC    = 5'd6;
  localparam logic [4:0] S_DECIDE = 5'd7;
  localparam logic [4:0] S_EMUL   = 5'd8;
  localparam logic [4:0] S_EDIVST = 5'd9;
  localparam logic [4:0] S_EDIVW  = 5'd10;
  localparam logic [4:0] S_ESUM   = 5'd11;
  localparam logic [4:0] S_SQM    = 5'd12;
  localparam logic [4:0] S_SQW    = 5'd13;
  localparam logic [4:0] S_CMP    = 5'd14;
  localparam logic [4:0] S_SW1    = 5'd15;
  localparam logic [4:0] S_SW2    = 5'd16;
  localparam logic [4:0] S_RDSLOT = 5'd17;

  logic [4:0] state_q, state_d;

  logic [NUM_REPLICAS_W-1:0] num_replicas_q;
  logic [NUM_PARAMS_W-1:0]   num_params_q;
  logic [NRW-1:0]            nr;
  logic [NPW-1:0]            np;

  rxp_cmd_e cmd;
  logic     accept;
  logic     bad_load, bad_swap, bad_read;
  logic [NRW-1:0] j_val;

  logic [RIW-1:0]       i_q, j_q, pi_q, pj_q;
  logic [NPW-1:0]       k_q;
  logic [CIW-1:0]       kcol;
  logic signed [31:0]   w_q, w_next, term;
  logic [31:0]          pa_q, da_q;
  logic                 neg_q;
  logic [31:0]          x_q, t_q, s_q, s_val;
  logic [ACC_W-1:0]     pos_q, negs_q, sum_diff;
  logic [DIVISOR_W-1:0] n_q;
  logic [1:0]           r_q;
  logic [15:0]          draw_q;

  logic signed [32:0] dp, dd, sum33;
  logic [31:0]        ma, mb;
  logic [47:0]        q48;
  logic [48:0]        qr;

  // memory, multiplier and divider controls
  logic            tab_we;
  logic [AW-1:0]   par_addr, der_addr;
  logic [31:0]     par_rd, der_rd;
  logic            perm_we, perm_clear;
  logic [RIW-1:0]  perm_addr, perm_wdata, perm_rd;
  logic            mul_en;
  logic [MUL_W-1:0] mul_a, mul_b;
  logic [PROD_W-1:0] prod;
  logic            div_start, div_done;
  logic [MUL_W-1:0] quo;

  // result strobe
  logic emit, emit_bad, emit_acc, emit_swap, emit_read;
  logic        done_q, accepted_q, bad_q;
  logic [3:0]  first_q, second_q, slot_q;
  logic [31:0] attempts_q, accepts_q;

  function automatic logic [AW-1:0] tab_addr(logic [RIW-1:0] row, logic [CIW-1:0] col);
    return AW'(int'(row) * MAX_PARAMS + int'(col));
  endfunction

  // effective counts and request checks
  assign nr = (NRW'(num_replicas_q) > NRW'(MAX_REPLICAS)) ? NRW'(MAX_REPLICAS)
                                                           : NRW'(num_replicas_q);
  assign np = (NPW'(num_params_q) > NPW'(MAX_PARAMS)) ? NPW'(MAX_PARAMS)
                                                     : NPW'(num_params_q);
  assign cmd      = rxp_cmd_e'(cmd_i);
  assign accept   = start && !busy;
  assign bad_load = (NRW'(replica_i) >= nr) || (NPW'(param_index_i) >= np);
  assign bad_read = NRW'(replica_i) >= nr;
  assign bad_swap = (nr < NRW'(2)) || (NRW'(first_pick_i) >= nr)
                 || (NRW'(second_pick_i) >= nr - NRW'(1));
  assign j_val    = NRW'(second_pick_i) + NRW'(second_pick_i >= first_pick_i);
  assign kcol     = k_q[CIW-1:0];

  // configuration
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_replicas_q <= NUM_REPLICAS_W'(2);
      num_params_q   <= NUM_PARAMS_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == REG_NUM_REPLICAS) begin
        num_replicas_q <= cfg_data_i[NUM_REPLICAS_W-1:0];
      end else if (cfg_index_i == REG_NUM_PARAMS) begin
        num_params_q <= cfg_data_i[NUM_PARAMS_W-1:0];
      end
    end
  end

  // weight term: differences, sign-magnitude product, floor and saturation
  assign dp = {pa_q[31], pa_q} - {par_rd[31], par_rd};
  assign dd = {da_q[31], da_q} - {der_rd[31], der_rd};
  assign ma = dp[32] ? 32'(-dp) : dp[31:0];
  assign mb = dd[32] ? 32'(-dd) : dd[31:0];
  assign q48 = prod[63:16];
  assign qr  = {1'b0, q48} + 49'(prod[15:0] != 16'd0);

  always_comb begin
    if (neg_q) begin
      term = (qr > 49'h0_8000_0000) ? W_MIN : $signed(~qr[31:0] + 32'd1);
    end else begin
      term = (q48 > 48'h7FFF_FFFF) ? W_MAX : $signed(q48[31:0]);
    end
    sum33 = {w_q[31], w_q} + {term[31], term};
    if (sum33[32] != sum33[31]) begin
      w_next = sum33[32] ? W_MIN : W_MAX;
    end else begin
      w_next = sum33[31:0];
    end
  end

  // series sum, clamped to Q0.32
  assign sum_diff = pos_q - negs_q;
  assign s_val = (pos_q <= negs_q) ? 32'd0
               : (sum_diff > ACC_W'(33'h0_FFFF_FFFF)) ? 32'hFFFF_FFFF : sum_diff[31:0];

  // sequencer
  always_comb begin
    state_d    = state_q;
    emit       = 1'b0;
    emit_bad   = 1'b0;
    emit_acc   = 1'b0;
    emit_swap  = 1'b0;
    emit_read  = 1'b0;
    tab_we     = 1'b0;
    par_addr   = tab_addr(pj_q, kcol);
    der_addr   = tab_addr(i_q, kcol);
    perm_we    = 1'b0;
    perm_clear = 1'b0;
    perm_addr  = i_q;
    perm_wdata = pj_q;
    mul_en     = 1'b0;
    mul_a      = t_q;
    mul_b      = x_q;
    div_start  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_LOAD: begin
              emit     = 1'b1;
              emit_bad = bad_load;
              tab_we   = !bad_load;
              par_addr = tab_addr(RIW'(replica_i), CIW'(param_index_i));
              der_addr = tab_addr(RIW'(replica_i), CIW'(param_index_i));
            end
            CMD_PERM_RST: begin
              emit       = 1'b1;
              perm_clear = 1'b1;
            end
            CMD_SWAP: begin
              perm_addr = RIW'(first_pick_i);
              if (bad_swap) begin
                emit     = 1'b1;
                emit_bad = 1'b1;
              end else begin
                state_d = S_PI;
              end
            end
            CMD_READ: begin
              perm_addr = RIW'(replica_i);
              if (bad_read) begin
                emit     = 1'b1;
                emit_bad = 1'b1;
              end else begin
                state_d = S_RDSLOT;
              end
            end
            default: ;
          endcase
        end
      end
      S_RDSLOT: begin
        emit      = 1'b1;
        emit_read = 1'b1;
        state_d   = S_IDLE;
      end
      S_PI: begin
        perm_addr = j_q;
        state_d   = S_PJ;
      end
      S_PJ:   state_d = (np == '0) ? S_DECIDE : S_RD_A;
      S_RD_A: state_d = S_RD_B;
      S_RD_B: begin
        par_addr = tab_addr(pi_q, kcol);
        der_addr = tab_addr(j_q, kcol);
        state_d  = S_DIFF;
      end
      S_DIFF: begin
        mul_en  = 1'b1;
        mul_a   = ma;
        mul_b   = mb;
        state_d = S_ACC;
      end
      S_ACC: state_d = (NPW'(k_q + 1'b1) == np) ? S_DECIDE : S_RD_A;
      S_DECIDE: begin
        if (w_q <= 32'sd0) begin
          state_d = S_SW1;
        end else if (w_q >= W_EXP_LIMIT) begin
          emit      = 1'b1;
          emit_swap = 1'b1;
          state_d   = S_IDLE;
        end else begin
          state_d = S_EMUL;
        end
      end
      S_EMUL: begin
        mul_en  = 1'b1;
        state_d = S_EDIVST;
      end
      S_EDIVST: begin
        div_start = 1'b1;
        state_d   = S_EDIVW;
      end
      S_EDIVW: begin
        if (div_done) begin
          state_d = (n_q == TAYLOR_LAST) ? S_ESUM : S_EMUL;
        end
      end
      S_ESUM: state_d = S_SQM;
      S_SQM: begin
        mul_en  = 1'b1;
        mul_a   = s_q;
        mul_b   = s_q;
        state_d = S_SQW;
      end
      S_SQW: state_d = (r_q == SQ_LAST) ? S_CMP : S_SQM;
      S_CMP: begin
        if (draw_q < s_q[31:16]) begin
          state_d = S_SW1;
        end else begin
          emit      = 1'b1;
          emit_swap = 1'b1;
          state_d   = S_IDLE;
        end
      end
      S_SW1: begin
        perm_we = 1'b1;
        state_d = S_SW2;
      end
      S_SW2: begin
        perm_we    = 1'b1;
        perm_addr  = j_q;
        perm_wdata = pi_q;
        emit       = 1'b1;
        emit_swap  = 1'b1;
        emit_acc   = 1'b1;
        state_d    = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          i_q    <= RIW'(first_pick_i);
          j_q    <= RIW'(j_val);
          draw_q <= uniform_draw_i;
        end
      end
      S_PI: pi_q <= perm_rd;
      S_PJ: begin
        pj_q <= perm_rd;
        k_q  <= '0;
        w_q  <= '0;
      end
      S_RD_B: begin
        pa_q <= par_rd;
        da_q <= der_rd;
      end
      S_DIFF: neg_q <= dp[32] ^ dd[32];
      S_ACC: begin
        w_q <= w_next;
        k_q <= k_q + 1'b1;
      end
      S_DECIDE: begin
        x_q    <= {w_q[19:0], 12'h000};
        t_q    <= {w_q[19:0], 12'h000};
        pos_q  <= ACC_W'(33'h1_0000_0000);
        negs_q <= ACC_W'({w_q[19:0], 12'h000});
        n_q    <= TAYLOR_FIRST;
      end
      S_EDIVW: begin
        if (div_done) begin
          t_q <= quo;
          if (n_q[0]) begin
            negs_q <= negs_q + ACC_W'(quo);
          end else begin
            pos_q <= pos_q + ACC_W'(quo);
          end
          n_q <= n_q + 1'b1;
        end
      end
      S_ESUM: begin
        s_q <= s_val;
        r_q <= '0;
      end
      S_SQW: begin
        s_q <= prod[63:32];
        r_q <= r_q + 1'b1;
      end
      default: ;
    endcase
  end

  // result strobe and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q     <= 1'b0;
      attempts_q <= '0;
      accepts_q  <= '0;
    end else begin
      done_q <= emit;
      if (emit && emit_swap) begin
        attempts_q <= attempts_q + 32'd1;
        if (emit_acc) begin
          accepts_q <= accepts_q + 32'd1;
        end
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      accepted_q <= emit_acc;
      first_q    <= emit_swap ? 4'(i_q) : 4'd0;
      second_q   <= emit_swap ? 4'(j_q) : 4'd0;
      slot_q     <= emit_read ? 4'(perm_rd) : 4'd0;
      bad_q      <= emit_bad;
    end
  end

  assign done_o           = done_q;
  assign accepted_o       = accepted_q;
  assign first_replica_o  = first_q;
  assign second_replica_o = second_q;
  assign slot_content_o   = slot_q;
  assign attempt_count_o  = attempts_q;
  assign accept_count_o   = accepts_q;
  assign bad_request_o    = bad_q;

  // tables
  rxp_ram #(.DEPTH(DEPTH), .WIDTH(32)) u_par_ram (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .addr_i  (par_addr),
    .wdata_i (state_value_i),
    .rdata_o (par_rd)
  );

  rxp_ram #(.DEPTH(DEPTH), .WIDTH(32)) u_der_ram (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .addr_i  (der_addr),
    .wdata_i (derivative_value_i),
    .rdata_o (der_rd)
  );

  rxp_perm #(.MAX_REPLICAS(MAX_REPLICAS)) u_perm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (perm_clear),
    .we_i    (perm_we),
    .addr_i  (perm_addr),
    .wdata_i (perm_wdata),
    .rdata_o (perm_rd)
  );

  rxp_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  rxp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod[63:32]),
    .divisor_i  (n_q),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // checks
  a_bad_not_accepted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(bad_request_o && accepted_o))
    else $error("rejected request reported as accepted swap");

  a_accept_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && accepted_o) |-> (accept_count_o == $past(accept_count_o) + 32'd1))
    else $error("accepted swap not counted");

  a_bad_no_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && bad_request_o) |-> $stable(attempt_count_o))
    else $error("rejected request changed attempt count");

  a_div_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_EDIVW))
    else $error("divider finished outside its wait state");

  a_swap_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SW2) |-> (i_q != j_q))
    else $error("swap of a slot with itself");

endmodule
